>>> hw/rtl/fcaa_pkg.sv
// ----------------------------------------------------------------------------
// Four-channel averager package
// Widths, register indexes, reset values and the sequencer state type
// shared by the averager and its serial arithmetic units.
// ----------------------------------------------------------------------------
package fcaa_pkg;

    // Field and datapath widths
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 32;
    localparam int GAIN_BITS   = 16;
    localparam int VALUE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int CH_BITS     = 2;
    localparam int NUM_CH      = 4;
    localparam int PROD_BITS   = SUM_BITS + GAIN_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
    localparam int MUL_CNT_BITS = $clog2(GAIN_BITS);
    localparam int CFG_IDX_BITS = 2;

    // Channel codes
    localparam logic [CH_BITS-1:0] CH_TEMP = 2'd3;
    localparam logic [CH_BITS-1:0] CH_LAST = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_RATE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_TEMP   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_TEMP = 2'd2;

    // Configuration reset values
    localparam logic [GAIN_BITS-1:0]  GAIN_RATE_RST   = 16'd819;
    localparam logic [GAIN_BITS-1:0]  GAIN_TEMP_RST   = 16'd13107;
    localparam logic [VALUE_BITS-1:0] OFFSET_TEMP_RST = 32'd2949120;

    // Input mode codes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_DUMP  = 1'b1;

    // Dump sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_MUL    = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

endpackage

>>> hw/rtl/four_channel_accumulate_average.sv
// A dump handles each channel in turn: check, serial divide, serial multiply and result
// steps for a channel with samples, and only the check and result steps for an empty
// channel; an output stall holds the result step.
// Throughput: one input transfer per cycle while accumulating; one item at a time
// during a dump. Reset is asynchronous, active low: sums, counts and held values clear.
// ----------------------------------------------------------------------------
// Four-channel accumulate-and-dump averager
// Accumulates signed samples per channel and, on a dump, emits the scaled
// mean of each channel, or its held previous value if it is empty, in channel order using serial divide and multiply.
// ----------------------------------------------------------------------------
module four_channel_accumulate_average
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fcaa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fcaa_pkg::VALUE_BITS-1:0]     cfg_data,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [fcaa_pkg::CH_BITS-1:0]        channel,
    input  logic signed [fcaa_pkg::SAMPLE_BITS-1:0] sample,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fcaa_pkg::CH_BITS-1:0]        out_channel,
    output logic signed [fcaa_pkg::VALUE_BITS-1:0] value,
    output logic                                valid_res,
    output logic                                all_valid,
    output logic                                last
);

    fcaa_pkg::state_t                      state_reg;
    fcaa_pkg::state_t                      state_next;
    logic [fcaa_pkg::CH_BITS-1:0]          ch_reg;
    logic [fcaa_pkg::CH_BITS-1:0]          ch_next;
    logic                                  all_ok_reg;
    logic                                  all_ok_next;

    logic [fcaa_pkg::GAIN_BITS-1:0]        gain_rate_reg;
    logic [fcaa_pkg::GAIN_BITS-1:0]        gain_temp_reg;
    logic [fcaa_pkg::VALUE_BITS-1:0]       offset_temp_reg;

    logic [fcaa_pkg::SUM_BITS-1:0]         sum_reg   [fcaa_pkg::NUM_CH];
    logic [fcaa_pkg::COUNT_BITS-1:0]       count_reg [fcaa_pkg::NUM_CH];
    logic [fcaa_pkg::VALUE_BITS-1:0]       prev_reg  [fcaa_pkg::NUM_CH];

    logic                                  out_valid_reg;
    logic [fcaa_pkg::CH_BITS-1:0]          out_channel_reg;
    logic [fcaa_pkg::VALUE_BITS-1:0]       value_reg;
    logic                                  valid_res_reg;
    logic                                  all_valid_reg;
    logic                                  last_reg;

    logic                                  in_xfer;
    logic                                  out_xfer;
    logic                                  out_free;
    logic [fcaa_pkg::CH_BITS-1:0]          idx;
    logic [fcaa_pkg::SUM_BITS-1:0]         sum_sel;
    logic [fcaa_pkg::COUNT_BITS-1:0]       count_sel;
    logic                                  has_samples;
    logic                                  is_temp;
    logic                                  accum_en;
    logic                                  load_en;
    logic                                  div_start;
    logic                                  div_done;
    logic [fcaa_pkg::SUM_BITS-1:0]         mean;
    logic                                  mul_start;
    logic                                  mul_done;
    logic [fcaa_pkg::PROD_BITS-1:0]        product;
    logic [fcaa_pkg::GAIN_BITS-1:0]        gain_sel;
    logic [fcaa_pkg::VALUE_BITS-1:0]       offset_sel;
    logic [fcaa_pkg::PROD_BITS:0]          full_sum;
    logic [fcaa_pkg::VALUE_BITS-1:0]       sat_value;
    logic [fcaa_pkg::VALUE_BITS-1:0]       result_value;

    // Handshakes
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != fcaa_pkg::S_IDLE);

    // One channel is addressed at a time: the input's channel when idle,
    // the dump's channel otherwise.
    assign idx         = (state_reg == fcaa_pkg::S_IDLE) ? channel : ch_reg;
    assign sum_sel     = sum_reg[idx];
    assign count_sel   = count_reg[idx];
    assign has_samples = (count_sel != '0);
    assign is_temp     = (ch_reg == fcaa_pkg::CH_TEMP);
    assign gain_sel    = is_temp ? gain_temp_reg : gain_rate_reg;
    assign offset_sel  = is_temp ? offset_temp_reg : '0;

    // Scale result: product plus offset, saturated to 32 bits.
    assign full_sum = {product[fcaa_pkg::PROD_BITS-1], product}
                    + {{(fcaa_pkg::PROD_BITS + 1 - fcaa_pkg::VALUE_BITS)
                        {offset_sel[fcaa_pkg::VALUE_BITS-1]}}, offset_sel};

    always_comb
    begin
        if (full_sum[fcaa_pkg::PROD_BITS:fcaa_pkg::VALUE_BITS-1] == '0 ||
            full_sum[fcaa_pkg::PROD_BITS:fcaa_pkg::VALUE_BITS-1] == '1)
        begin
            sat_value = full_sum[fcaa_pkg::VALUE_BITS-1:0];
        end
        else if (full_sum[fcaa_pkg::PROD_BITS])
        begin
            sat_value = {1'b1, {(fcaa_pkg::VALUE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(fcaa_pkg::VALUE_BITS-1){1'b1}}};
        end
    end

    assign result_value = has_samples ? sat_value : prev_reg[ch_reg];

    // Dump sequencer
    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        all_ok_next = all_ok_reg;
        accum_en    = 1'b0;
        load_en     = 1'b0;
        div_start   = 1'b0;
        mul_start   = 1'b0;
        case (state_reg)
            fcaa_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode == fcaa_pkg::MODE_DUMP)
                    begin
                        ch_next     = '0;
                        all_ok_next = 1'b1;
                        state_next  = fcaa_pkg::S_CHECK;
                    end
                    else
                    begin
                        accum_en = (count_sel != '1);
                    end
                end
            end
            fcaa_pkg::S_CHECK:
            begin
                if (has_samples)
                begin
                    div_start  = 1'b1;
                    state_next = fcaa_pkg::S_DIV;
                end
                else
                begin
                    state_next = fcaa_pkg::S_RESULT;
                end
            end
            fcaa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = fcaa_pkg::S_MUL;
                end
            end
            fcaa_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = fcaa_pkg::S_RESULT;
                end
            end
            fcaa_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    load_en     = 1'b1;
                    all_ok_next = all_ok_reg && has_samples;
                    if (ch_reg == fcaa_pkg::CH_LAST)
                    begin
                        state_next = fcaa_pkg::S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = fcaa_pkg::S_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = fcaa_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fcaa_pkg::S_IDLE;
            ch_reg     <= '0;
            all_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            all_ok_reg <= all_ok_next;
        end
    end

    // Configuration registers; writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_rate_reg   <= fcaa_pkg::GAIN_RATE_RST;
            gain_temp_reg   <= fcaa_pkg::GAIN_TEMP_RST;
            offset_temp_reg <= fcaa_pkg::OFFSET_TEMP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fcaa_pkg::REG_GAIN_RATE:   gain_rate_reg   <= cfg_data[fcaa_pkg::GAIN_BITS-1:0];
                fcaa_pkg::REG_GAIN_TEMP:   gain_temp_reg   <= cfg_data[fcaa_pkg::GAIN_BITS-1:0];
                fcaa_pkg::REG_OFFSET_TEMP: offset_temp_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Channel state: accumulate on a sample, clear and hold the new value on a result for a channel with samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcaa_pkg::NUM_CH; i++)
            begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else if (accum_en)
        begin
            sum_reg[idx]   <= sum_sel + {{(fcaa_pkg::SUM_BITS - fcaa_pkg::SAMPLE_BITS)
                                          {sample[fcaa_pkg::SAMPLE_BITS-1]}}, sample};
            count_reg[idx] <= count_sel + 1'b1;
        end
        else if (load_en && has_samples)
        begin
            sum_reg[idx]   <= '0;
            count_reg[idx] <= '0;
            prev_reg[idx]  <= sat_value;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            out_channel_reg <= ch_reg;
            value_reg       <= result_value;
            valid_res_reg   <= has_samples;
            last_reg        <= (ch_reg == fcaa_pkg::CH_LAST);
            all_valid_reg   <= (ch_reg == fcaa_pkg::CH_LAST) && all_ok_reg && has_samples;
        end
    end

    // Serial divider: mean of the addressed channel
    fcaa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sel),
        .divisor  (count_sel),
        .done     (div_done),
        .quotient (mean)
    );

    // Serial multiplier: mean times the channel's gain
    fcaa_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mean),
        .mplier  (gain_sel),
        .done    (mul_done),
        .product (product)
    );

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign value       = value_reg;
    assign valid_res   = valid_res_reg;
    assign all_valid   = all_valid_reg;
    assign last        = last_reg;

endmodule

>>> hw/rtl/fcaa_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a signed sum by an unsigned nonzero count, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fcaa_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fcaa_pkg::SUM_BITS-1:0]   dividend,
    input  logic [fcaa_pkg::COUNT_BITS-1:0] divisor,
    output logic                            done,
    output logic [fcaa_pkg::SUM_BITS-1:0]   quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [fcaa_pkg::DIV_CNT_BITS-1:0]   cnt_reg;
    logic [fcaa_pkg::COUNT_BITS-1:0]     rem_reg;
    logic [fcaa_pkg::COUNT_BITS-1:0]     rem_next;
    logic [fcaa_pkg::SUM_BITS-1:0]       quo_reg;
    logic [fcaa_pkg::COUNT_BITS-1:0]     dsr_reg;
    logic                                neg_reg;
    logic [fcaa_pkg::SUM_BITS-1:0]       magnitude;
    logic [fcaa_pkg::COUNT_BITS:0]       trial;
    logic [fcaa_pkg::COUNT_BITS:0]       diff;
    logic                                fits;

    // Magnitude of the dividend; the most negative sum maps to its unsigned value.
    assign magnitude = dividend[fcaa_pkg::SUM_BITS-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign trial    = {rem_reg, quo_reg[fcaa_pkg::SUM_BITS-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign fits     = (trial >= {1'b0, dsr_reg});
    assign rem_next = fits ? diff[fcaa_pkg::COUNT_BITS-1:0]
                           : trial[fcaa_pkg::COUNT_BITS-1:0];

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == fcaa_pkg::DIV_CNT_BITS'(fcaa_pkg::SUM_BITS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == fcaa_pkg::DIV_CNT_BITS'(fcaa_pkg::SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in as the dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude;
            dsr_reg <= divisor;
            neg_reg <= dividend[fcaa_pkg::SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[fcaa_pkg::SUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

>>> hw/rtl/fcaa_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product of a signed mean and an unsigned gain, one gain
// bit per cycle.
// ----------------------------------------------------------------------------
module fcaa_mul
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fcaa_pkg::SUM_BITS-1:0]    mcand,
    input  logic [fcaa_pkg::GAIN_BITS-1:0]   mplier,
    output logic                             done,
    output logic [fcaa_pkg::PROD_BITS-1:0]   product
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [fcaa_pkg::MUL_CNT_BITS-1:0]   cnt_reg;
    logic [fcaa_pkg::PROD_BITS-1:0]      acc_reg;
    logic [fcaa_pkg::PROD_BITS-1:0]      acc_next;
    logic [fcaa_pkg::PROD_BITS-1:0]      mcand_reg;
    logic [fcaa_pkg::GAIN_BITS-1:0]      mplier_reg;

    // Add the shifted multiplicand when the current gain bit is set.
    assign acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // Control: bit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == fcaa_pkg::MUL_CNT_BITS'(fcaa_pkg::GAIN_BITS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == fcaa_pkg::MUL_CNT_BITS'(fcaa_pkg::GAIN_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: multiplicand shifts left, gain shifts right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{fcaa_pkg::GAIN_BITS{mcand[fcaa_pkg::SUM_BITS-1]}}, mcand};
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[fcaa_pkg::PROD_BITS-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[fcaa_pkg::GAIN_BITS-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
